@@ rtl/cfb_pkg.sv @@
// ----------------------------------------------------------------------------
// cfb_pkg: shared types, constants and function of the command frame builder
// Byte select codes, controller/datapath bundles and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package cfb_pkg;

    localparam int DefMaxArgs  = 4;   // default argument slots
    localparam int ArgFields   = 4;   // argument fields on the input port
    localparam int CountWidth  = 3;

    localparam logic [7:0]  SyncHi   = 8'hEB;
    localparam logic [7:0]  SyncLo   = 8'h90;
    localparam logic [7:0]  TermByte = 8'hC5;
    localparam logic [15:0] CrcPoly  = 16'h8408;

    // byte select codes
    typedef logic [3:0] t_sel;
    localparam t_sel SEL_SYNC_HI = 4'd0;
    localparam t_sel SEL_SYNC_LO = 4'd1;
    localparam t_sel SEL_CODE_HI = 4'd2;
    localparam t_sel SEL_CODE_LO = 4'd3;
    localparam t_sel SEL_ZERO    = 4'd4;
    localparam t_sel SEL_COUNT   = 4'd5;
    localparam t_sel SEL_ARG     = 4'd6;
    localparam t_sel SEL_CRC_HI  = 4'd7;
    localparam t_sel SEL_CRC_LO  = 4'd8;
    localparam t_sel SEL_TERM    = 4'd9;

    // controller -> datapath
    typedef struct packed {
        logic load;       // latch a new command, clear CRC
        logic emit;       // put the selected byte into the output register
        logic feed;       // run the emitted byte through the CRC
        logic last;       // emitted byte ends the frame
        logic arg_shift;  // next byte of the current argument
        logic arg_next;   // move to the next argument
        t_sel sel;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic                  out_free;  // output register can take a byte
        logic [CountWidth-1:0] count;     // clamped argument count
    } t_dp_stat;

    // CRC-16 KERMIT, reflected, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CrcPoly;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/cfb_ctrl.sv @@
// ----------------------------------------------------------------------------
// cfb_ctrl: frame sequencer
// Walks header, arg and tail bytes: one byte command per cycle unless stalled.
// ----------------------------------------------------------------------------
module cfb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cfb_pkg::t_dp_stat  i_stat,
    output cfb_pkg::t_dp_cmd   o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_HEAD = 2'd1;
    localparam logic [1:0] S_ARG  = 2'd2;
    localparam logic [1:0] S_TAIL = 2'd3;

    logic [1:0] r_state, n_state;
    logic [2:0] r_pos, n_pos;            // header 0..5, tail 0..3
    logic [1:0] r_bidx, n_bidx;          // byte within argument
    logic [cfb_pkg::CountWidth-1:0] r_left, n_left;

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_bidx  = r_bidx;
        n_left  = r_left;
        o_cmd   = '0;
        o_cmd.sel = cfb_pkg::SEL_ZERO;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_HEAD;
                    n_pos      = 3'd0;
                end
            end
            S_HEAD: begin
                unique case (r_pos)
                    3'd0:    o_cmd.sel = cfb_pkg::SEL_SYNC_HI;
                    3'd1:    o_cmd.sel = cfb_pkg::SEL_SYNC_LO;
                    3'd2:    o_cmd.sel = cfb_pkg::SEL_CODE_HI;
                    3'd3:    o_cmd.sel = cfb_pkg::SEL_CODE_LO;
                    3'd4:    o_cmd.sel = cfb_pkg::SEL_ZERO;
                    default: o_cmd.sel = cfb_pkg::SEL_COUNT;
                endcase
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.feed = 1'b1;
                    if (r_pos == 3'd5) begin
                        n_pos = 3'd0;
                        if (i_stat.count != '0) begin
                            n_state = S_ARG;
                            n_left  = i_stat.count;
                            n_bidx  = 2'd0;
                        end else begin
                            n_state = S_TAIL;
                        end
                    end else begin
                        n_pos = r_pos + 3'd1;
                    end
                end
            end
            S_ARG: begin
                o_cmd.sel = cfb_pkg::SEL_ARG;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.feed = 1'b1;
                    n_bidx     = r_bidx + 2'd1;
                    if (r_bidx == 2'd3) begin
                        o_cmd.arg_next = 1'b1;
                        n_left         = r_left - cfb_pkg::CountWidth'(1);
                        if (r_left == cfb_pkg::CountWidth'(1)) begin
                            n_state = S_TAIL;
                            n_pos   = 3'd0;
                        end
                    end else begin
                        o_cmd.arg_shift = 1'b1;
                    end
                end
            end
            S_TAIL: begin
                unique case (r_pos[1:0])
                    2'd0:    o_cmd.sel = cfb_pkg::SEL_CRC_HI;
                    2'd1:    o_cmd.sel = cfb_pkg::SEL_CRC_LO;
                    default: o_cmd.sel = cfb_pkg::SEL_TERM;
                endcase
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_pos[1:0] == 2'd3) begin
                        o_cmd.last = 1'b1;
                        n_state    = S_IDLE;
                        n_pos      = 3'd0;
                    end else begin
                        n_pos = r_pos + 3'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= 3'd0;
            r_bidx  <= 2'd0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_bidx  <= n_bidx;
            r_left  <= n_left;
        end
    end

endmodule

@@ rtl/cfb_datapath.sv @@
// ----------------------------------------------------------------------------
// cfb_datapath: command hold registers, byte mux, CRC and output register
// Arguments sit in a shift line; the head word is sent MSB byte first.
// ----------------------------------------------------------------------------
module cfb_datapath #(
    parameter int MAX_ARGS = cfb_pkg::DefMaxArgs
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cfb_pkg::t_dp_cmd              i_cmd,
    output cfb_pkg::t_dp_stat             o_stat,
    input  logic [15:0]                   i_command_code,
    input  logic [cfb_pkg::CountWidth-1:0] i_arg_count,
    input  logic signed [31:0]            i_arg_zero,
    input  logic signed [31:0]            i_arg_one,
    input  logic signed [31:0]            i_arg_two,
    input  logic signed [31:0]            i_arg_three,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [7:0]                    o_frame_byte,
    output logic                          o_last_byte
);

    logic [15:0]                    r_code;
    logic [cfb_pkg::CountWidth-1:0] r_count;
    logic [31:0]                    r_args [MAX_ARGS];
    logic [31:0]                    arg_in [cfb_pkg::ArgFields];
    logic [15:0]                    r_crc;
    logic                           r_valid;
    logic [7:0]                     r_byte;
    logic                           r_last;
    logic [7:0]                     byte_sel;

    assign arg_in[0] = i_arg_zero;
    assign arg_in[1] = i_arg_one;
    assign arg_in[2] = i_arg_two;
    assign arg_in[3] = i_arg_three;

    always_comb begin
        unique case (i_cmd.sel)
            cfb_pkg::SEL_SYNC_HI: byte_sel = cfb_pkg::SyncHi;
            cfb_pkg::SEL_SYNC_LO: byte_sel = cfb_pkg::SyncLo;
            cfb_pkg::SEL_CODE_HI: byte_sel = r_code[15:8];
            cfb_pkg::SEL_CODE_LO: byte_sel = r_code[7:0];
            cfb_pkg::SEL_COUNT:   byte_sel = {{(8-cfb_pkg::CountWidth){1'b0}}, r_count};
            cfb_pkg::SEL_ARG:     byte_sel = r_args[0][31:24];
            cfb_pkg::SEL_CRC_HI:  byte_sel = r_crc[15:8];
            cfb_pkg::SEL_CRC_LO:  byte_sel = r_crc[7:0];
            cfb_pkg::SEL_TERM:    byte_sel = cfb_pkg::TermByte;
            default:              byte_sel = 8'h00;
        endcase
    end

    // command hold: count saturates at MAX_ARGS, slots past the port read zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_code <= i_command_code;
            if (int'(i_arg_count) > MAX_ARGS) begin
                r_count <= cfb_pkg::CountWidth'(MAX_ARGS);
            end else begin
                r_count <= i_arg_count;
            end
            for (int i = 0; i < MAX_ARGS; i++) begin
                r_args[i] <= (i < cfb_pkg::ArgFields) ? arg_in[i % cfb_pkg::ArgFields]
                                                      : 32'h0;
            end
        end else if (i_cmd.arg_next) begin
            for (int i = 0; i < MAX_ARGS - 1; i++) begin
                r_args[i] <= r_args[i+1];
            end
            r_args[MAX_ARGS-1] <= 32'h0;
        end else if (i_cmd.arg_shift) begin
            r_args[0] <= {r_args[0][23:0], 8'h00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= 16'h0000;
        end else if (i_cmd.load) begin
            r_crc <= 16'h0000;
        end else if (i_cmd.emit && i_cmd.feed) begin
            r_crc <= cfb_pkg::crc_byte(r_crc, byte_sel);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_byte <= byte_sel;
            r_last <= i_cmd.last;
        end
    end

    assign o_stat.out_free = !r_valid || !i_out_stall;
    assign o_stat.count    = r_count;
    assign o_out_valid     = r_valid;
    assign o_frame_byte    = r_byte;
    assign o_last_byte     = r_last;

endmodule

@@ rtl/command_frame_builder_crc16.sv @@
// ----------------------------------------------------------------------------
// A command transfer latches the hold registers; the sequencer then emits the
// first frame byte into the output register, and bytes follow one per cycle
// when not stalled. A new command is taken only while the sequencer is idle,
// once the final byte of the previous frame has entered the output register.
// Reset: synchronous, active low; clears the sequencer, CRC and output valid.
// ----------------------------------------------------------------------------
// command_frame_builder_crc16: serial command frame builder
// Frame: EB 90, code (BE16), count (BE16), args (BE32 each), CRC-16 KERMIT
// (reflected 0x8408, init 0, high byte first), C5 C5 with last on the final byte.
// ----------------------------------------------------------------------------
module command_frame_builder_crc16 #(
    parameter int MAX_ARGS = cfb_pkg::DefMaxArgs   // 1..8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command transfer
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [15:0]                    i_command_code,
    input  logic [cfb_pkg::CountWidth-1:0] i_arg_count,
    input  logic signed [31:0]             i_arg_zero,
    input  logic signed [31:0]             i_arg_one,
    input  logic signed [31:0]             i_arg_two,
    input  logic signed [31:0]             i_arg_three,
    // byte transfer
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [7:0]                     o_frame_byte,
    output logic                           o_last_byte
);

    cfb_pkg::t_dp_cmd  dp_cmd;
    cfb_pkg::t_dp_stat dp_stat;

    // Sequencer: takes a command only when idle. The last byte of a frame may
    // still wait in the output register while the next command transfers.
    cfb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // Datapath: hold registers, byte mux, bytewise CRC, output register.
    cfb_datapath #(
        .MAX_ARGS (MAX_ARGS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_command_code (i_command_code),
        .i_arg_count    (i_arg_count),
        .i_arg_zero     (i_arg_zero),
        .i_arg_one      (i_arg_one),
        .i_arg_two      (i_arg_two),
        .i_arg_three    (i_arg_three),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_frame_byte   (o_frame_byte),
        .o_last_byte    (o_last_byte)
    );

endmodule
